// ===== design/ttp_pkg.sv =====
package ttp_pkg;

    localparam int HANDLE_W = 5;
    localparam int DUR_W    = 32;
    localparam int ACTION_W = 3;

    localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SETUP  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] handle;
        logic [DUR_W-1:0]    duration;
    } t_in_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] new_handle;
        logic                ok;
    } t_out_item;

endpackage

// ===== design/timeout_timer_pool.sv =====
// Pool of ENTRIES countdown timers, addressed by handles 1..ENTRIES (0 means none).
// Input channel: an item (action, handle, duration) is taken at a rising edge where
// start is high and busy is low. Output channel: each item yields exactly one result
// (new_handle, ok), shown on o_result for a single cycle while o_strobe is high.
// The receiver cannot stall, so results are never held back or queued.
// Steps per item, from acceptance to the strobe:
//   setup, cancel, check, query with a valid handle: one RAM read, then the write-back
//   setup, cancel, check, query with an invalid handle, or an unused action code: answered from idle
//   create: a scan over the assigned flags from entry 0 upwards, up to the first free entry
//   tick: one read-modify-write of the count RAM per entry, pipelined
// busy drops in the cycle the strobe is shown, so a new item may start then.
// Reset clears the assigned flags and the sequencer; the count RAM is not cleared,
// since an unassigned entry reads as zero through its assigned flag. No clearing
// pass is needed and the block accepts items from the first cycle after reset.
module timeout_timer_pool #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ttp_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output ttp_pkg::t_out_item  o_result
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Each RAM word holds the armed flag above the remaining count.
    localparam int WORD_W = COUNT_BITS + 1;
    localparam int WIDE_W = IDX_W + ttp_pkg::HANDLE_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OP   = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_TICK = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ENTRIES-1:0]  r_assigned, n_assigned;
    logic                r_strobe, n_strobe;
    ttp_pkg::t_out_item  r_result, n_result;
    ttp_pkg::t_in_item   r_item;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                accept;
    logic                in_valid;
    logic [WIDE_W-1:0]   in_idx_wide;
    logic [IDX_W-1:0]    in_idx;
    logic [WORD_W-1:0]   cur_word;
    logic                cur_armed;
    logic [COUNT_BITS-1:0] cur_rem;
    logic [COUNT_BITS-1:0] rem_dec;
    logic [IDX_W-1:0]    idx_next;
    logic [WIDE_W-1:0]   grant_wide;
    logic                at_last;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Handle check and conversion to an entry index.
    assign in_valid    = (i_item.handle != '0) &&
                         (9'(i_item.handle) <= 9'(ENTRIES));
    assign in_idx_wide = WIDE_W'(i_item.handle) - WIDE_W'(1);
    assign in_idx      = in_idx_wide[IDX_W-1:0];

    // An unassigned entry has never been written since reset and reads as zero.
    assign cur_word  = r_assigned[r_idx] ? ram_rdata : '0;
    assign cur_armed = cur_word[COUNT_BITS];
    assign cur_rem   = cur_word[COUNT_BITS-1:0];
    assign rem_dec   = cur_rem - COUNT_BITS'(1);

    assign idx_next   = r_idx + IDX_W'(1);
    assign grant_wide = WIDE_W'(r_idx) + WIDE_W'(1);
    assign at_last    = (r_idx == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_assigned = r_assigned;
        n_strobe   = 1'b0;
        n_result   = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = '0;
        ram_raddr  = r_idx;

        case (r_state)
            S_IDLE: begin
                // The read for a single-entry action is issued in the accepting cycle.
                ram_raddr = in_idx;
                if (accept) begin
                    case (i_item.action)
                        ttp_pkg::ACT_CREATE: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        ttp_pkg::ACT_SETUP, ttp_pkg::ACT_CANCEL,
                        ttp_pkg::ACT_CHECK, ttp_pkg::ACT_QUERY: begin
                            if (in_valid) begin
                                n_idx   = in_idx;
                                n_state = S_OP;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        ttp_pkg::ACT_TICK: begin
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_TICK;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_OP: begin
                case (r_item.action)
                    ttp_pkg::ACT_SETUP: begin
                        if (r_assigned[r_idx]) begin
                            ram_we      = 1'b1;
                            ram_wdata   = {1'b1, r_item.duration[COUNT_BITS-1:0]};
                            n_result.ok = 1'b1;
                        end
                    end
                    ttp_pkg::ACT_CANCEL: begin
                        if (cur_armed) begin
                            ram_we      = 1'b1;
                            ram_wdata   = '0;
                            n_result.ok = 1'b1;
                        end
                    end
                    ttp_pkg::ACT_CHECK: begin
                        // Expired: report once and disarm; the count is already zero.
                        if (cur_armed && (cur_rem == '0)) begin
                            ram_we      = 1'b1;
                            ram_wdata   = '0;
                            n_result.ok = 1'b1;
                        end
                    end
                    ttp_pkg::ACT_QUERY: begin
                        n_result.ok = cur_armed;
                    end
                    default: begin
                        n_result.ok = 1'b0;
                    end
                endcase
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_SCAN: begin
                // Lowest free entry wins; a freshly claimed timer is disarmed at zero.
                if (!r_assigned[r_idx]) begin
                    n_assigned[r_idx]   = 1'b1;
                    ram_we              = 1'b1;
                    ram_wdata           = '0;
                    n_result.new_handle = grant_wide[ttp_pkg::HANDLE_W-1:0];
                    n_result.ok         = 1'b1;
                    n_strobe            = 1'b1;
                    n_state             = S_IDLE;
                end else if (at_last) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_next;
                end
            end

            S_TICK: begin
                // Data for r_idx is here; write it back while reading the next entry.
                if (r_assigned[r_idx] && (cur_rem != '0)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {cur_armed, rem_dec};
                end
                if (at_last) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    ram_raddr = idx_next;
                    n_idx     = idx_next;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_assigned <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_assigned <= n_assigned;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_item <= i_item;
        end
    end

    // Writes happen only while busy, and a read is issued only once the previous
    // write has landed, so no forwarding path is needed around the RAM.
    ttp_ram #(
        .DEPTH  (ENTRIES),
        .WIDTH  (WORD_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Assigned entries are never released.
    a_assigned_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_assigned & $past(r_assigned)) == $past(r_assigned))
        else $error("assigned flag cleared");

    // The count RAM is written only by the sequencer, never while idle.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_IDLE))
        else $error("RAM write while idle");

    // A granted handle always comes with a success flag.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.new_handle != '0)) |-> o_result.ok)
        else $error("handle granted without ok");

    // The last entry of a tick walk ends the item with a plain result.
    a_tick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TICK) && at_last) |=> (o_strobe && !o_result.ok && !busy))
        else $error("tick walk did not finish cleanly");

    // No result appears unless an item was taken or the sequencer was at work.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(accept) || $past(busy)))
        else $error("result without an item");

endmodule

// ===== design/ttp_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module ttp_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 33,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/ttp_checker.sv =====
`timescale 1ns / 100ps

module ttp_checker #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  ttp_pkg::t_in_item  i_item,
    input  logic               i_strobe,
    input  ttp_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        ttp_pkg::t_in_item  cause;
        ttp_pkg::t_out_item want;
    } t_owed_reply;

    logic                  assigned [ENTRIES];
    logic                  armed    [ENTRIES];
    logic [COUNT_BITS-1:0] remaining[ENTRIES];

    t_owed_reply replies_owed[$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    // Applies one item to the local copy of the pool and returns the reply it should give.
    function automatic ttp_pkg::t_out_item apply_action(input ttp_pkg::t_in_item it);
        ttp_pkg::t_out_item res;
        logic               in_range;
        logic               found;
        int                 slot;
        res      = '0;
        found    = 1'b0;
        in_range = (it.handle >= 1) && (it.handle <= ENTRIES);
        slot     = in_range ? int'(it.handle) - 1 : 0;
        case (it.action)
            ttp_pkg::ACT_CREATE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!found && !assigned[i]) begin
                        found          = 1'b1;
                        assigned[i]    = 1'b1;
                        armed[i]       = 1'b0;
                        remaining[i]   = '0;
                        res.new_handle = ttp_pkg::HANDLE_W'(i + 1);
                        res.ok         = 1'b1;
                    end
                end
            end
            ttp_pkg::ACT_SETUP: begin
                if (in_range && assigned[slot]) begin
                    armed[slot]     = 1'b1;
                    remaining[slot] = it.duration[COUNT_BITS-1:0];
                    res.ok          = 1'b1;
                end
            end
            ttp_pkg::ACT_CANCEL: begin
                if (in_range && armed[slot]) begin
                    armed[slot]     = 1'b0;
                    remaining[slot] = '0;
                    res.ok          = 1'b1;
                end
            end
            ttp_pkg::ACT_CHECK: begin
                if (in_range && armed[slot] && remaining[slot] == '0) begin
                    armed[slot] = 1'b0;
                    res.ok      = 1'b1;
                end
            end
            ttp_pkg::ACT_QUERY: begin
                res.ok = in_range && armed[slot];
            end
            ttp_pkg::ACT_TICK: begin
                // Every nonzero count moves down, armed or not.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (remaining[i] != '0) begin
                        remaining[i] = remaining[i] - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_owed_reply head;
        t_owed_reply entry;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                assigned[i]  = 1'b0;
                armed[i]     = 1'b0;
                remaining[i] = '0;
            end
            replies_owed.delete();
        end else begin
            // A reply always belongs to an earlier item, so compare before taking a new one.
            if (i_strobe) begin
                if (replies_owed.size() == 0) begin
                    $display("%0t: unexpected reply new_handle=%0d ok=%0d",
                             $time, i_result.new_handle, i_result.ok);
                    mismatches++;
                end else begin
                    head = replies_owed.pop_front();
                    if (i_result.new_handle !== head.want.new_handle) begin
                        $display("%0t: new_handle expected %0d, actual %0d (action %0d handle %0d)",
                                 $time, head.want.new_handle, i_result.new_handle,
                                 head.cause.action, head.cause.handle);
                        mismatches++;
                    end
                    if (i_result.ok !== head.want.ok) begin
                        $display("%0t: ok expected %0d, actual %0d (action %0d handle %0d)",
                                 $time, head.want.ok, i_result.ok,
                                 head.cause.action, head.cause.handle);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                entry.cause = i_item;
                entry.want  = apply_action(i_item);
                replies_owed.push_back(entry);
            end
        end
        o_pending <= replies_owed.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int ENTRIES     = 16;
    localparam int COUNT_BITS  = 32;
    localparam int RANDOM_ITEMS = 1950;
    // The slowest correct run is about 2000 items, each at most a tick walk plus an idle gap;
    // the limit sits far above that.
    localparam int CYCLE_LIMIT = 500000;

    // Action codes that the block does not use; they must still give an empty reply.
    localparam logic [ttp_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ttp_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    ttp_pkg::t_in_item  item_in = '0;
    logic               strobe;
    ttp_pkg::t_out_item result;

    int        mismatches;
    int        results_owed;
    int        cycles = 0;
    logic      idling_on = 1'b1;

    timeout_timer_pool #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item_in),
        .o_strobe (strobe),
        .o_result (result)
    );

    // The checker sits beside the block, watches both channels and keeps its own copy of
    // the pool; the top only makes stimulus and gives the verdict.
    ttp_checker #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item_in),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (mismatches),
        .o_pending    (results_owed)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost reply ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Presents one item and holds it until the block takes it. Start is left high on
    // return, so a following item goes straight on without start dropping in between.
    // Now and then the sender instead drops start and goes quiet before returning, so that
    // gaps land on every phase of the block's work, including the middle of a tick walk.
    task automatic issue(input logic [ttp_pkg::ACTION_W-1:0] action,
                         input logic [ttp_pkg::HANDLE_W-1:0] handle,
                         input logic [ttp_pkg::DUR_W-1:0]    duration);
        start           <= 1'b1;
        item_in.action   <= action;
        item_in.handle   <= handle;
        item_in.duration <= duration;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (idling_on && $urandom_range(99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every reply owed has come back. The first edge lets
    // the owed count catch up with an item taken at the edge just gone.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
    endtask

    // Builds one random item. Creates are rare enough that the pool fills slowly, so the
    // early part sees setups of unassigned entries and later creates meet a full pool.
    // Ticks are frequent and most counts short, so timers actually run out and are seen
    // expiring; a few counts use every bit of the field, or its top value.
    task automatic issue_random();
        logic [ttp_pkg::ACTION_W-1:0] action;
        logic [ttp_pkg::HANDLE_W-1:0] handle;
        logic [ttp_pkg::DUR_W-1:0]    duration;
        int                           pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            action = ttp_pkg::ACT_CREATE;
        end else if (pick < 27) begin
            action = ttp_pkg::ACT_SETUP;
        end else if (pick < 35) begin
            action = ttp_pkg::ACT_CANCEL;
        end else if (pick < 58) begin
            action = ttp_pkg::ACT_CHECK;
        end else if (pick < 70) begin
            action = ttp_pkg::ACT_QUERY;
        end else if (pick < 96) begin
            action = ttp_pkg::ACT_TICK;
        end else begin
            action = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
        end

        // Mostly handles within the pool; the rest is handle zero or handles past the pool.
        if ($urandom_range(99) < 8) begin
            handle = $urandom_range(1) ? ttp_pkg::HANDLE_W'(0) :
                                         ttp_pkg::HANDLE_W'($urandom_range(17, 31));
        end else begin
            handle = ttp_pkg::HANDLE_W'($urandom_range(1, ENTRIES));
        end

        pick = $urandom_range(99);
        if (action != ttp_pkg::ACT_SETUP) begin
            duration = $urandom;
        end else if (pick < 60) begin
            duration = $urandom_range(0, 4);
        end else if (pick < 85) begin
            duration = $urandom_range(5, 30);
        end else if (pick < 95) begin
            duration = $urandom;
        end else begin
            duration = '1;
        end
        issue(action, handle, duration);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Before any create, every handle is unassigned: checks, setups and
        // cancels must all be refused, as must handle zero, handles past the pool and the
        // two unused action codes. A tick on an empty pool must change nothing.
        issue(ttp_pkg::ACT_CHECK,  5'd1,  32'd0);
        issue(ttp_pkg::ACT_SETUP,  5'd1,  32'd5);
        issue(ttp_pkg::ACT_SETUP,  5'd0,  32'd5);
        issue(ttp_pkg::ACT_QUERY,  5'd17, 32'd0);
        issue(ttp_pkg::ACT_CANCEL, 5'd31, 32'd0);
        issue(ACT_SPARE_6,         5'd1,  32'd0);
        issue(ACT_SPARE_7,         5'd31, 32'hFFFF_FFFF);
        issue(ttp_pkg::ACT_TICK,   5'd0,  32'd0);
        // Two creates hand out handles one and two in order.
        issue(ttp_pkg::ACT_CREATE, 5'd0,  32'd0);
        issue(ttp_pkg::ACT_CREATE, 5'd0,  32'd0);
        // A zero count is armed and already expired; expiry is reported only once.
        issue(ttp_pkg::ACT_SETUP,  5'd1,  32'd0);
        issue(ttp_pkg::ACT_QUERY,  5'd1,  32'd0);
        issue(ttp_pkg::ACT_CHECK,  5'd1,  32'd0);
        issue(ttp_pkg::ACT_CHECK,  5'd1,  32'd0);
        // A check while the count is still running leaves the timer armed.
        issue(ttp_pkg::ACT_SETUP,  5'd2,  32'd2);
        issue(ttp_pkg::ACT_CHECK,  5'd2,  32'd0);
        issue(ttp_pkg::ACT_TICK,   5'd0,  32'd0);
        issue(ttp_pkg::ACT_TICK,   5'd0,  32'd0);
        issue(ttp_pkg::ACT_CHECK,  5'd2,  32'd0);
        // The largest count, then a cancel of an armed timer and one of an idle timer.
        issue(ttp_pkg::ACT_SETUP,  5'd1,  32'hFFFF_FFFF);
        issue(ttp_pkg::ACT_TICK,   5'd0,  32'd0);
        issue(ttp_pkg::ACT_CANCEL, 5'd1,  32'd0);
        issue(ttp_pkg::ACT_CANCEL, 5'd1,  32'd0);
        issue(ttp_pkg::ACT_SETUP,  5'd16, 32'd3);
        issue(ttp_pkg::ACT_QUERY,  5'd2,  32'd0);
        drain();

        // Random part. A long stretch in the middle runs with no idling at all, and now
        // and then the sender holds back until every reply has come home.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = !(n >= 800 && n < 1200);
            if (n % 350 == 175) begin
                drain();
            end
            issue_random();
        end

        // Let the last replies arrive, then give the block a full tick walk of spare
        // cycles, so that a stray reply would still be caught.
        drain();
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
